>>> hw/rtl/slx_pkg.sv
package slx_pkg;

    // Input item: one script byte or the end-of-input marker
    typedef struct packed {
        logic [7:0] byte_req;
        logic       end_of_input;
    } in_t;

    // Result item: one token, one identifier character or one error
    typedef struct packed {
        logic [2:0]         token_kind;
        logic [7:0]         sym_char;
        logic signed [31:0] value;
        logic               ident_first;
        logic               ident_last;
        logic [2:0]         error_code;
        logic               run_last;
    } out_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic [2:0] level;
        logic       room;
    } q_stat_t;

    // Token kinds
    localparam logic [2:0] KIND_SYMBOL = 3'd0;
    localparam logic [2:0] KIND_CONST  = 3'd1;
    localparam logic [2:0] KIND_SEMI   = 3'd2;
    localparam logic [2:0] KIND_OPEN   = 3'd3;
    localparam logic [2:0] KIND_CLOSE  = 3'd4;
    localparam logic [2:0] KIND_IDENT  = 3'd5;
    localparam logic [2:0] KIND_END    = 3'd6;
    localparam logic [2:0] KIND_ERROR  = 3'd7;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_PROHIBITED = 3'd1;
    localparam logic [2:0] ERR_LETTER     = 3'd2;
    localparam logic [2:0] ERR_NAME_START = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW   = 3'd4;

    // Lexer modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_SIGN  = 3'd1;
    localparam logic [2:0] MODE_NUM   = 3'd2;
    localparam logic [2:0] MODE_IDENT = 3'd3;
    localparam logic [2:0] MODE_ERROR = 3'd4;

    // Character codes with a role of their own
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_SEMI  = 8'd59;
    localparam logic [7:0] CH_OPEN  = 8'd91;
    localparam logic [7:0] CH_CLOSE = 8'd93;
    localparam logic [7:0] CH_UNDER = 8'd95;

    localparam logic [34:0] MAG_MAX = 35'd2147483647;

    localparam out_t RES_NONE = '0;

endpackage

>>> hw/rtl/slx_step.sv
module slx_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  slx_pkg::in_t  item,
    output slx_pkg::out_t res0,
    output slx_pkg::out_t res1,
    output logic [1:0]    n_res
);

    logic [2:0]  mode_reg, mode_next;
    logic [30:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [7:0]  held_reg, held_next;
    logic        first_reg, first_next;

    logic [7:0]  c;
    logic [3:0]  dig;
    logic        c_digit, c_alpha, c_space, c_prohib, c_symbol;
    logic [34:0] prod;
    logic [31:0] const_val;

    // Idle-mode handling of the current byte
    logic          idle_emit;
    slx_pkg::out_t idle_res;
    logic [2:0]    idle_mode;
    logic          idle_neg;
    logic [30:0]   idle_mag;
    logic [7:0]    idle_held;
    logic          idle_first;

    slx_pkg::out_t r0, r1;
    logic [1:0]    n;

    // Classify the byte
    always_comb
    begin
        c        = item.byte_req;
        dig      = c[3:0];
        c_digit  = (c >= 8'd48) && (c <= 8'd57);
        c_alpha  = ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
        c_space  = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
        c_prohib = 1'b0;
        c_symbol = 1'b0;
        unique case (c)
            8'd36, 8'd35, 8'd37, 8'd39, 8'd34, 8'd63, 8'd64, 8'd92:
                c_prohib = 1'b1;
            8'd33, 8'd38, 8'd40, 8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47,
            8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd91, 8'd93, 8'd94, 8'd123,
            8'd124, 8'd125, 8'd126:
                c_symbol = 1'b1;
            default:
                c_symbol = 1'b0;
        endcase
    end

    // Accumulate one decimal digit: times ten by two shifts
    always_comb
    begin
        prod      = ({4'd0, mag_reg} << 3) + ({4'd0, mag_reg} << 1) + {31'd0, dig};
        const_val = neg_reg ? (32'd0 - {1'b0, mag_reg}) : {1'b0, mag_reg};
    end

    // Start a token from idle
    always_comb
    begin
        idle_emit  = 1'b0;
        idle_res   = slx_pkg::RES_NONE;
        idle_mode  = slx_pkg::MODE_IDLE;
        idle_neg   = neg_reg;
        idle_mag   = mag_reg;
        idle_held  = held_reg;
        idle_first = first_reg;
        priority if (c_space)
        begin
            idle_mode = slx_pkg::MODE_IDLE;
        end
        else if (c_prohib)
        begin
            idle_emit           = 1'b1;
            idle_res.token_kind = slx_pkg::KIND_ERROR;
            idle_res.error_code = slx_pkg::ERR_PROHIBITED;
            idle_mode           = slx_pkg::MODE_ERROR;
        end
        else if (c_symbol)
        begin
            priority if ((c == slx_pkg::CH_PLUS) || (c == slx_pkg::CH_MINUS))
            begin
                idle_mode = slx_pkg::MODE_SIGN;
                idle_neg  = (c == slx_pkg::CH_MINUS);
            end
            else if (c == slx_pkg::CH_SEMI)
            begin
                idle_emit           = 1'b1;
                idle_res.token_kind = slx_pkg::KIND_SEMI;
            end
            else if (c == slx_pkg::CH_OPEN)
            begin
                idle_emit           = 1'b1;
                idle_res.token_kind = slx_pkg::KIND_OPEN;
            end
            else if (c == slx_pkg::CH_CLOSE)
            begin
                idle_emit           = 1'b1;
                idle_res.token_kind = slx_pkg::KIND_CLOSE;
            end
            else
            begin
                idle_emit           = 1'b1;
                idle_res.token_kind = slx_pkg::KIND_SYMBOL;
                idle_res.sym_char   = c;
            end
        end
        else if (c_digit)
        begin
            idle_mode = slx_pkg::MODE_NUM;
            idle_neg  = 1'b0;
            idle_mag  = {27'd0, dig};
        end
        else if (c_alpha || (c == slx_pkg::CH_UNDER))
        begin
            idle_mode  = slx_pkg::MODE_IDENT;
            idle_held  = c;
            idle_first = 1'b1;
        end
        else
        begin
            idle_emit           = 1'b1;
            idle_res.token_kind = slx_pkg::KIND_ERROR;
            idle_res.error_code = slx_pkg::ERR_NAME_START;
            idle_mode           = slx_pkg::MODE_ERROR;
        end
    end

    // Step the lexer on one item
    always_comb
    begin
        mode_next  = mode_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        held_next  = held_reg;
        first_next = first_reg;
        r0         = slx_pkg::RES_NONE;
        r1         = slx_pkg::RES_NONE;
        n          = 2'd0;

        if (item.end_of_input)
        begin
            // Flush the pending token, then close the script
            r1.token_kind = slx_pkg::KIND_END;
            unique case (mode_reg)
                slx_pkg::MODE_SIGN:
                begin
                    r0.token_kind = slx_pkg::KIND_SYMBOL;
                    r0.sym_char   = neg_reg ? slx_pkg::CH_MINUS : slx_pkg::CH_PLUS;
                    n             = 2'd2;
                end
                slx_pkg::MODE_NUM:
                begin
                    r0.token_kind = slx_pkg::KIND_CONST;
                    r0.value      = const_val;
                    n             = 2'd2;
                end
                slx_pkg::MODE_IDENT:
                begin
                    r0.token_kind  = slx_pkg::KIND_IDENT;
                    r0.sym_char    = held_reg;
                    r0.ident_first = first_reg;
                    r0.ident_last  = 1'b1;
                    n              = 2'd2;
                end
                default:
                begin
                    r0 = r1;
                    n  = 2'd1;
                end
            endcase
            mode_next  = slx_pkg::MODE_IDLE;
            mag_next   = '0;
            neg_next   = 1'b0;
            held_next  = '0;
            first_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                slx_pkg::MODE_ERROR:
                begin
                    n = 2'd0;
                end
                slx_pkg::MODE_SIGN:
                begin
                    if (c_digit)
                    begin
                        mode_next = slx_pkg::MODE_NUM;
                        mag_next  = {27'd0, dig};
                    end
                    else
                    begin
                        r0.token_kind = slx_pkg::KIND_SYMBOL;
                        r0.sym_char   = neg_reg ? slx_pkg::CH_MINUS : slx_pkg::CH_PLUS;
                        r1            = idle_res;
                        n             = idle_emit ? 2'd2 : 2'd1;
                        mode_next     = idle_mode;
                        mag_next      = idle_mag;
                        neg_next      = idle_neg;
                        held_next     = idle_held;
                        first_next    = idle_first;
                    end
                end
                slx_pkg::MODE_NUM:
                begin
                    priority if (c_digit)
                    begin
                        if (prod > slx_pkg::MAG_MAX)
                        begin
                            r0.token_kind = slx_pkg::KIND_ERROR;
                            r0.error_code = slx_pkg::ERR_OVERFLOW;
                            n             = 2'd1;
                            mode_next     = slx_pkg::MODE_ERROR;
                        end
                        else
                        begin
                            mag_next = prod[30:0];
                        end
                    end
                    else if (c_alpha)
                    begin
                        r0.token_kind = slx_pkg::KIND_ERROR;
                        r0.error_code = slx_pkg::ERR_LETTER;
                        n             = 2'd1;
                        mode_next     = slx_pkg::MODE_ERROR;
                    end
                    else
                    begin
                        r0.token_kind = slx_pkg::KIND_CONST;
                        r0.value      = const_val;
                        r1            = idle_res;
                        n             = idle_emit ? 2'd2 : 2'd1;
                        mode_next     = idle_mode;
                        mag_next      = idle_mag;
                        neg_next      = idle_neg;
                        held_next     = idle_held;
                        first_next    = idle_first;
                    end
                end
                slx_pkg::MODE_IDENT:
                begin
                    r0.token_kind  = slx_pkg::KIND_IDENT;
                    r0.sym_char    = held_reg;
                    r0.ident_first = first_reg;
                    if (c_alpha || c_digit || (c == slx_pkg::CH_UNDER))
                    begin
                        n          = 2'd1;
                        held_next  = c;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        r0.ident_last = 1'b1;
                        r1            = idle_res;
                        n             = idle_emit ? 2'd2 : 2'd1;
                        mode_next     = idle_mode;
                        mag_next      = idle_mag;
                        neg_next      = idle_neg;
                        held_next     = idle_held;
                        first_next    = idle_first;
                    end
                end
                default:
                begin
                    r0         = idle_res;
                    n          = idle_emit ? 2'd1 : 2'd0;
                    mode_next  = idle_mode;
                    mag_next   = idle_mag;
                    neg_next   = idle_neg;
                    held_next  = idle_held;
                    first_next = idle_first;
                end
            endcase
        end

        // Mark the last result of this item
        if (n == 2'd2)
        begin
            r1.run_last = 1'b1;
        end
        else
        begin
            r0.run_last = 1'b1;
        end
    end

    assign res0  = r0;
    assign res1  = r1;
    assign n_res = n;

    // Hold lexer state; advance on each stepped item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= slx_pkg::MODE_IDLE;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            held_reg  <= '0;
            first_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            held_reg  <= held_next;
            first_reg <= first_next;
        end
    end

endmodule

>>> hw/rtl/slx_outq.sv
module slx_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [1:0]       push_n,
    input  slx_pkg::out_t    din0,
    input  slx_pkg::out_t    din1,
    input  logic             pop,
    output logic             dout_valid,
    output slx_pkg::out_t    dout,
    output slx_pkg::q_stat_t stat
);

    slx_pkg::out_t entry_reg [4];
    logic [1:0]    wr_reg, wr_next;
    logic [1:0]    rd_reg, rd_next;
    logic [2:0]    level_reg, level_next;
    logic [1:0]    wr_plus1;
    logic [2:0]    add_n;

    // Advance pointers and fill level
    always_comb
    begin
        wr_plus1   = wr_reg + 2'd1;
        add_n      = push ? {1'b0, push_n} : 3'd0;
        wr_next    = wr_reg + add_n[1:0];
        rd_next    = pop ? (rd_reg + 2'd1) : rd_reg;
        level_next = level_reg + add_n - {2'd0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            level_reg <= level_next;
        end
    end

    // Write up to two results per cycle
    always_ff @(posedge clk)
    begin
        if (push && (push_n != 2'd0))
        begin
            entry_reg[wr_reg] <= din0;
        end
        if (push && (push_n == 2'd2))
        begin
            entry_reg[wr_plus1] <= din1;
        end
    end

    assign dout_valid = (level_reg != 3'd0);
    assign dout       = entry_reg[rd_reg];
    assign stat.level = level_reg;
    assign stat.room  = (level_reg <= 3'd2);

endmodule

>>> hw/rtl/script_lexer.sv
// Streaming tokenizer for script text. One byte (or the end-of-input marker)
// is taken per transfer on the item channel, and tokens leave on the token
// channel, one result per transfer, each with run_last set on the last result
// an item causes. An item is registered, stepped through the lexer once the
// result queue has room, and its results are written to a four-entry result
// queue, from which the token channel is fed. The block
// takes one item per cycle while each item yields at most one result and the
// queue keeps room; an item that yields two (a token ended by a byte that
// starts another, or end of input with a token pending) fills two queue
// entries, and the queue absorbs them, so the sustained rate is one result
// per cycle while the token receiver does not stall. The lexer steps only
// when the queue has room for two results, which is what stalls the item
// channel. Identifier characters come out one byte late, because each one
// is held until the next byte decides its last mark. After an error the block
// drops every byte until the end-of-input item.
module script_lexer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  slx_pkg::in_t  item,
    output logic          token_valid,
    input  logic          token_stall,
    output slx_pkg::out_t token
);

    logic             in_valid_reg, in_valid_next;
    slx_pkg::in_t     in_data_reg;
    logic             fire;
    logic             item_take;
    slx_pkg::out_t    res0, res1;
    logic [1:0]       n_res;
    slx_pkg::q_stat_t q_stat;
    logic             token_take;

    // Step the registered item when the queue can take two results
    assign fire       = in_valid_reg && q_stat.room;
    assign item_stall = in_valid_reg && !q_stat.room;
    assign item_take  = item_valid && !item_stall;
    assign token_take = token_valid && !token_stall;

    always_comb
    begin
        priority if (item_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the input payload
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            in_data_reg <= item;
        end
    end

    slx_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_data_reg),
        .res0  (res0),
        .res1  (res1),
        .n_res (n_res)
    );

    slx_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .push_n     (n_res),
        .din0       (res0),
        .din1       (res1),
        .pop        (token_take),
        .dout_valid (token_valid),
        .dout       (token),
        .stat       (q_stat)
    );

    // Never step into a queue without room for two results
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (q_stat.level <= 3'd2))
        else $error("lexer stepped with result queue too full");

    // A stalled item always sits in the input register
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_valid_reg)
        else $error("item stall without a held item");

    // A step that yields results makes a token visible next cycle
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (n_res != 2'd0)) |=> token_valid)
        else $error("results of a step were lost");

    // The end token always closes its item's results
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && (token.token_kind == slx_pkg::KIND_END)) |-> token.run_last)
        else $error("end token without run_last");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 200;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_REPORTS  = 40;
    localparam int HOLD_CYCLES  = 150;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef enum int {GEN_NUMBER, GEN_NAME, GEN_SYMBOL, GEN_BAD} gen_kind_e;

    string symbol_chars     = "!&()*+,-./:;<=>[]^{|}~";
    string prohibited_chars = "$#%'\"?@\\";

    logic          clk         = 1'b0;
    logic          rst_n       = 1'b0;
    logic          item_valid  = 1'b0;
    logic          item_stall;
    slx_pkg::in_t  item        = '0;
    logic          token_valid;
    logic          token_stall = 1'b0;
    slx_pkg::out_t token;

    // lexer model state
    logic [2:0]  lx_mode       = slx_pkg::MODE_IDLE;
    logic [30:0] lx_mag        = '0;
    logic        lx_neg        = 1'b0;
    logic [7:0]  lx_held       = '0;
    logic        lx_held_first = 1'b0;

    slx_pkg::out_t expected_tokens[$];
    slx_pkg::out_t step_tokens[$];

    int error_count     = 0;
    int token_count     = 0;
    int live_items      = 0;
    int cycle_count     = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_request    = 0;
    int hold_left       = 0;

    script_lexer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token       (token)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic bit char_is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit char_is_letter(logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic bit char_is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit char_in_set(logic [7:0] c, string set);
        for (int i = 0; i < set.len(); i++)
        begin
            if (set[i] == c)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------
    function automatic void add_token(logic [2:0] kind, logic [7:0] ch,
                                      logic signed [31:0] val, logic first,
                                      logic last, logic [2:0] err);
        slx_pkg::out_t t;
        t.token_kind  = kind;
        t.sym_char    = ch;
        t.value       = val;
        t.ident_first = first;
        t.ident_last  = last;
        t.error_code  = err;
        t.run_last    = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void enter_error(logic [2:0] err);
        add_token(slx_pkg::KIND_ERROR, 8'd0, 32'sd0, 1'b0, 1'b0, err);
        lx_mode = slx_pkg::MODE_ERROR;
    endfunction

    function automatic logic signed [31:0] const_value();
        logic signed [31:0] v;
        v = {1'b0, lx_mag};
        return lx_neg ? -v : v;
    endfunction

    // Classify one byte with nothing pending
    function automatic void lex_from_idle(logic [7:0] c);
        lx_mode = slx_pkg::MODE_IDLE;
        if (char_is_space(c))
            return;
        if (char_in_set(c, prohibited_chars))
            enter_error(slx_pkg::ERR_PROHIBITED);
        else if (char_in_set(c, symbol_chars))
        begin
            if (c == slx_pkg::CH_PLUS || c == slx_pkg::CH_MINUS)
            begin
                lx_mode = slx_pkg::MODE_SIGN;
                lx_neg  = (c == slx_pkg::CH_MINUS);
            end
            else if (c == slx_pkg::CH_SEMI)
                add_token(slx_pkg::KIND_SEMI, 8'd0, 32'sd0, 1'b0, 1'b0, slx_pkg::ERR_NONE);
            else if (c == slx_pkg::CH_OPEN)
                add_token(slx_pkg::KIND_OPEN, 8'd0, 32'sd0, 1'b0, 1'b0, slx_pkg::ERR_NONE);
            else if (c == slx_pkg::CH_CLOSE)
                add_token(slx_pkg::KIND_CLOSE, 8'd0, 32'sd0, 1'b0, 1'b0, slx_pkg::ERR_NONE);
            else
                add_token(slx_pkg::KIND_SYMBOL, c, 32'sd0, 1'b0, 1'b0, slx_pkg::ERR_NONE);
        end
        else if (char_is_digit(c))
        begin
            lx_mode = slx_pkg::MODE_NUM;
            lx_neg  = 1'b0;
            lx_mag  = {23'd0, c - CH_ZERO};
        end
        else if (char_is_letter(c) || c == slx_pkg::CH_UNDER)
        begin
            lx_mode       = slx_pkg::MODE_IDENT;
            lx_held       = c;
            lx_held_first = 1'b1;
        end
        else
            enter_error(slx_pkg::ERR_NAME_START);
    endfunction

    // Advance the model by one accepted item and queue its tokens
    task automatic lex_step(input slx_pkg::in_t it);
        logic [7:0]    c;
        logic [63:0]   grown;
        slx_pkg::out_t last_tok;
        c = it.byte_req;
        step_tokens.delete();
        live_items++;

        if (it.end_of_input)
        begin
            // flush whatever is pending, then close the script
            if (lx_mode == slx_pkg::MODE_SIGN)
                add_token(slx_pkg::KIND_SYMBOL, lx_neg ? slx_pkg::CH_MINUS : slx_pkg::CH_PLUS,
                          32'sd0, 1'b0, 1'b0, slx_pkg::ERR_NONE);
            else if (lx_mode == slx_pkg::MODE_NUM)
                add_token(slx_pkg::KIND_CONST, 8'd0, const_value(), 1'b0, 1'b0,
                          slx_pkg::ERR_NONE);
            else if (lx_mode == slx_pkg::MODE_IDENT)
                add_token(slx_pkg::KIND_IDENT, lx_held, 32'sd0, lx_held_first, 1'b1,
                          slx_pkg::ERR_NONE);
            add_token(slx_pkg::KIND_END, 8'd0, 32'sd0, 1'b0, 1'b0, slx_pkg::ERR_NONE);
            lx_mode       = slx_pkg::MODE_IDLE;
            lx_mag        = '0;
            lx_neg        = 1'b0;
            lx_held       = '0;
            lx_held_first = 1'b0;
        end
        else if (lx_mode != slx_pkg::MODE_ERROR)
        begin
            case (lx_mode)
                slx_pkg::MODE_SIGN:
                begin
                    if (char_is_digit(c))
                    begin
                        lx_mode = slx_pkg::MODE_NUM;
                        lx_mag  = {23'd0, c - CH_ZERO};
                    end
                    else
                    begin
                        add_token(slx_pkg::KIND_SYMBOL,
                                  lx_neg ? slx_pkg::CH_MINUS : slx_pkg::CH_PLUS, 32'sd0,
                                  1'b0, 1'b0, slx_pkg::ERR_NONE);
                        lex_from_idle(c);
                    end
                end
                slx_pkg::MODE_NUM:
                begin
                    if (char_is_digit(c))
                    begin
                        grown = {33'd0, lx_mag} * 64'd10 + {56'd0, c} - 64'd48;
                        if (grown > {29'd0, slx_pkg::MAG_MAX})
                            enter_error(slx_pkg::ERR_OVERFLOW);
                        else
                            lx_mag = grown[30:0];
                    end
                    else if (char_is_letter(c))
                        enter_error(slx_pkg::ERR_LETTER);
                    else
                    begin
                        add_token(slx_pkg::KIND_CONST, 8'd0, const_value(), 1'b0, 1'b0,
                                  slx_pkg::ERR_NONE);
                        lex_from_idle(c);
                    end
                end
                slx_pkg::MODE_IDENT:
                begin
                    // the held char goes out now; its last mark depends on this byte
                    if (char_is_letter(c) || char_is_digit(c) || c == slx_pkg::CH_UNDER)
                    begin
                        add_token(slx_pkg::KIND_IDENT, lx_held, 32'sd0, lx_held_first,
                                  1'b0, slx_pkg::ERR_NONE);
                        lx_held       = c;
                        lx_held_first = 1'b0;
                    end
                    else
                    begin
                        add_token(slx_pkg::KIND_IDENT, lx_held, 32'sd0, lx_held_first,
                                  1'b1, slx_pkg::ERR_NONE);
                        lex_from_idle(c);
                    end
                end
                default:
                    lex_from_idle(c);
            endcase
        end

        // mark the last token of this item and hand all of them to the checker
        if (step_tokens.size() > 0)
        begin
            last_tok = step_tokens.pop_back();
            last_tok.run_last = 1'b1;
            step_tokens.push_back(last_tok);
        end
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at token %0d, %s: expected 0x%0h, got 0x%0h",
                     token_count, what, want, got);
    endtask

    // Compare each token transfer with the oldest expected token
    always @(posedge clk)
    begin : token_check
        slx_pkg::out_t want;
        if (rst_n && token_valid && !token_stall)
        begin
            token_count++;
            if (expected_tokens.size() == 0)
                report_mismatch("token with nothing expected", 32'd0,
                                {29'd0, token.token_kind});
            else
            begin
                want = expected_tokens.pop_front();
                if (token.token_kind !== want.token_kind)
                    report_mismatch("token_kind", 32'(want.token_kind),
                                    32'(token.token_kind));
                if (token.sym_char !== want.sym_char)
                    report_mismatch("sym_char", 32'(want.sym_char), 32'(token.sym_char));
                if (token.value !== want.value)
                    report_mismatch("value", want.value, token.value);
                if (token.ident_first !== want.ident_first)
                    report_mismatch("ident_first", 32'(want.ident_first),
                                    32'(token.ident_first));
                if (token.ident_last !== want.ident_last)
                    report_mismatch("ident_last", 32'(want.ident_last),
                                    32'(token.ident_last));
                if (token.error_code !== want.error_code)
                    report_mismatch("error_code", 32'(want.error_code),
                                    32'(token.error_code));
                if (token.run_last !== want.run_last)
                    report_mismatch("run_last", 32'(want.run_last), 32'(token.run_last));
            end
        end
    end

    // Drive receiver stall: a requested hold-off first, else random
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            token_stall <= 1'b1;
        end
        else
            token_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // End the run if it takes far longer than any correct run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sending
    // ------------------------------------------------------------------
    // Offer one item after a random gap and hold it until the transfer
    task automatic send_item(input slx_pkg::in_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        lex_step(it);
    endtask

    task automatic send_char(input logic [7:0] c);
        slx_pkg::in_t it;
        it.byte_req     = c;
        it.end_of_input = 1'b0;
        send_item(it);
    endtask

    task automatic send_end();
        slx_pkg::in_t it;
        it.byte_req     = 8'($urandom);
        it.end_of_input = 1'b1;
        send_item(it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Drop valid and wait until every expected token has arrived
    task automatic wait_for_drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Script generation
    // ------------------------------------------------------------------
    function automatic logic [7:0] name_char(bit allow_digit);
        int r;
        r = $urandom_range(allow_digit ? 62 : 52);
        if (r < 26)
            return CH_UPPER_A + 8'(r);
        if (r < 52)
            return CH_LOWER_A + 8'(r - 26);
        if (r == 52)
            return slx_pkg::CH_UNDER;
        return CH_ZERO + 8'(r - 53);
    endfunction

    task automatic send_space();
        int n;
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++)
            send_char(($urandom_range(1) == 0) ? CH_SPACE : 8'($urandom_range(13, 9)));
    endtask

    task automatic send_number();
        longint unsigned mag;
        int roll;
        roll = $urandom_range(99);
        if (roll < 25)
            send_char(slx_pkg::CH_MINUS);
        else if (roll < 40)
            send_char(slx_pkg::CH_PLUS);
        if ($urandom_range(9) == 0)
            send_char(CH_ZERO);
        case ($urandom_range(3))
            0: mag = 64'($urandom_range(9));
            1: mag = 64'($urandom_range(99999));
            2: mag = 64'($urandom);
            default:
            begin
                // values around the overflow boundary
                case ($urandom_range(3))
                    0: mag = 64'd2147483647;
                    1: mag = 64'd2147483648;
                    2: mag = 64'd214748364;
                    default: mag = 64'd9999999999;
                endcase
            end
        endcase
        send_text($sformatf("%0d", mag));
    endtask

    task automatic send_name();
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
        send_char(name_char(1'b0));
        for (int i = 1; i < len; i++)
            send_char(name_char(1'b1));
    endtask

    task automatic send_bad_char();
        if ($urandom_range(1) == 0)
            send_char(prohibited_chars[$urandom_range(prohibited_chars.len() - 1)]);
        else
        begin
            case ($urandom_range(2))
                0: send_char(8'($urandom_range(8, 0)));
                1: send_char(8'($urandom_range(31, 14)));
                default: send_char(8'($urandom_range(255, 127)));
            endcase
        end
    endtask

    // One random script, mostly well-formed, closed by end of input
    task automatic run_script(input int n_tokens);
        gen_kind_e prev_kind;
        gen_kind_e next_kind;
        int roll;
        prev_kind = GEN_SYMBOL;
        for (int k = 0; k < n_tokens; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                next_kind = GEN_NUMBER;
            else if (roll < 62)
                next_kind = GEN_NAME;
            else if (roll < 98)
                next_kind = GEN_SYMBOL;
            else
                next_kind = GEN_BAD;
            // keep most numbers apart from a following name
            if (k > 0)
            begin
                if (prev_kind == GEN_NUMBER && next_kind == GEN_NAME)
                begin
                    if ($urandom_range(99) >= 3)
                        send_space();
                end
                else if ($urandom_range(99) >= 40)
                    send_space();
            end
            case (next_kind)
                GEN_NUMBER: send_number();
                GEN_NAME:   send_name();
                GEN_SYMBOL: send_char(symbol_chars[$urandom_range(symbol_chars.len() - 1)]);
                default:    send_bad_char();
            endcase
            prev_kind = next_kind;
        end
        if ($urandom_range(99) < 40)
            send_space();
        send_end();
    endtask

    // Fully random bytes with random end markers
    task automatic send_noise(input int n);
        slx_pkg::in_t it;
        for (int i = 0; i < n; i++)
        begin
            it.byte_req     = 8'($urandom);
            it.end_of_input = ($urandom_range(15) == 0);
            send_item(it);
        end
        send_end();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_constants();
        // most negative constant, ended by a bracket
        send_text("-2147483647]");
        // sign left pending at end of input
        send_text("-");
        send_end();
    endtask

    task automatic test_names();
        // sign before a name, name pending at end of input
        send_text("+_x");
        send_end();
        // underscore right after a number starts a name
        send_text("7_");
        send_end();
    endtask

    task automatic test_error_cases();
        // letter after a number, then silence until the end
        send_text("9a$");
        send_end();
        send_text("#");
        send_end();
        send_char(8'hFF);
        send_end();
    endtask

    task automatic test_random_scripts(input int send_pct, input int stall_pct,
                                       input int n_items);
        int goal;
        sender_idle_pct = send_pct;
        recv_stall_pct  = stall_pct;
        goal = live_items + n_items;
        while (live_items < goal)
        begin
            if ($urandom_range(19) == 0)
                send_noise($urandom_range(4, 16));
            else
                run_script($urandom_range(1, 25));
        end
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        // hold the receiver off while the sender keeps offering
        hold_request = HOLD_CYCLES;
        run_script(30);
        run_script(10);
    endtask

    task automatic test_sender_pause();
        sender_idle_pct = 0;
        recv_stall_pct  = 28;
        send_text("abc 12;");
        wait_for_drain();
        send_text(" +3 x");
        wait_for_drain();
        send_end();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_constants();
        test_names();
        test_error_cases();
        test_random_scripts(0, 0, PHASE_ITEMS);
        test_random_scripts(80, 0, PHASE_ITEMS);
        test_random_scripts(0, 80, PHASE_ITEMS);
        test_random_scripts(28, 28, PHASE_ITEMS);
        test_backpressure();
        test_sender_pause();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
